/* hdl/taa_pkg.sv */
// Shared types and constants for the triangle area accumulator.
// No dependencies; every other file imports this package.
package taa_pkg;

	localparam int COORD_W          = 16;  // port width of one coordinate field
	localparam int AREA_W           = 34;  // port width of double_area
	localparam int MESH_W           = 48;  // port width of mesh_total
	localparam int DEF_COORD_BITS   = 16;
	localparam int DEF_TOTAL_BITS   = 48;

	typedef struct packed {
		logic [COORD_W-1:0] ax;
		logic [COORD_W-1:0] ay;
		logic [COORD_W-1:0] az;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] by_coord;
		logic [COORD_W-1:0] bz;
		logic [COORD_W-1:0] vx;
		logic [COORD_W-1:0] vy;
		logic [COORD_W-1:0] vz;
		logic               last_triangle;
	} taa_in_t;

	typedef struct packed {
		logic [AREA_W-1:0] double_area;
		logic [MESH_W-1:0] mesh_total;
		logic              total_saturated;
		logic              mesh_done;
	} taa_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_ROOT,
		ST_ACC
	} taa_state_t;

	// what to do with the registered product in the next cycle
	typedef enum logic [2:0] {
		K_NONE,
		K_FIRST,
		K_SUB,
		K_LL,
		K_HL,
		K_HH
	} taa_kind_t;

endpackage

/* hdl/taa_if.sv */
// Valid/ready channel interfaces for triangle items and result items.
// Depends on taa_pkg for the payload structs.
interface taa_in_if import taa_pkg::*; ();
	logic    valid;
	logic    ready;
	taa_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface taa_out_if import taa_pkg::*; ();
	logic     valid;
	logic     ready;
	taa_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/taa_norm.sv */
// Squared cross-product norm: edge vectors, then cross and square terms
// through one shared registered multiplier. Depends on taa_pkg.
module taa_norm import taa_pkg::*; #(
	parameter  int COORD_BITS = DEF_COORD_BITS,
	localparam int RW         = 4*COORD_BITS + 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  taa_in_t       tri_in,
	output logic          done,
	output logic [RW-1:0] radicand
);

	localparam int EW   = COORD_BITS + 1;     // edge
	localparam int MULW = COORD_BITS + 2;     // multiplier operand, signed
	localparam int PW   = 2*MULW;             // product
	localparam int MW   = 2*COORD_BITS + 1;   // cross magnitude
	localparam int LW   = COORD_BITS + 1;     // low split of magnitude

	localparam logic [2:0] STEP_P1   = 3'd0;
	localparam logic [2:0] STEP_P2   = 3'd1;
	localparam logic [2:0] STEP_DIFF = 3'd2;
	localparam logic [2:0] STEP_LL   = 3'd3;
	localparam logic [2:0] STEP_HL   = 3'd4;
	localparam logic [2:0] STEP_HH   = 3'd5;
	localparam logic [1:0] COMP_X    = 2'd0;
	localparam logic [1:0] COMP_Y    = 2'd1;
	localparam logic [1:0] COMP_Z    = 2'd2;

	function automatic logic signed [EW-1:0] sx(input logic [COORD_W-1:0] r);
		return EW'(signed'(r[COORD_BITS-1:0]));
	endfunction

	logic signed [EW-1:0]   e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic                   busy_q, flush_q, done_q;
	logic [1:0]             comp_q;
	logic [2:0]             sub_q;
	taa_kind_t              kind_q, kind_d;
	logic signed [PW-1:0]   prod_q, acc_q;
	logic [MW-1:0]          mag_q;
	logic [RW-1:0]          rad_q;
	logic signed [EW-1:0]   p1a, p1b, p2a, p2b;
	logic signed [MULW-1:0] mul_a, mul_b, lo_op, hi_op;
	logic signed [PW-1:0]   diff, diff_neg;
	logic [RW-1:0]          prod_ext;

	assign lo_op    = signed'({1'b0, mag_q[LW-1:0]});
	assign hi_op    = signed'({2'b00, mag_q[MW-1:LW]});
	assign diff     = acc_q - prod_q;
	assign diff_neg = -diff;
	assign prod_ext = {{(RW-PW){1'b0}}, prod_q};

	// pair of products for the current cross component
	always_comb begin
		case (comp_q)
			COMP_X: begin
				p1a = e1y_q; p1b = e2z_q; p2a = e1z_q; p2b = e2y_q;
			end
			COMP_Y: begin
				p1a = e1z_q; p1b = e2x_q; p2a = e1x_q; p2b = e2z_q;
			end
			default: begin
				p1a = e1x_q; p1b = e2y_q; p2a = e1y_q; p2b = e2x_q;
			end
		endcase
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		kind_d = K_NONE;
		if (busy_q) begin
			case (sub_q)
				STEP_P1: begin
					mul_a = MULW'(p1a); mul_b = MULW'(p1b); kind_d = K_FIRST;
				end
				STEP_P2: begin
					mul_a = MULW'(p2a); mul_b = MULW'(p2b); kind_d = K_SUB;
				end
				STEP_DIFF: begin
					kind_d = K_NONE;  // waits for the magnitude
				end
				STEP_LL: begin
					mul_a = lo_op; mul_b = lo_op; kind_d = K_LL;
				end
				STEP_HL: begin
					mul_a = hi_op; mul_b = lo_op; kind_d = K_HL;
				end
				STEP_HH: begin
					mul_a = hi_op; mul_b = hi_op; kind_d = K_HH;
				end
				default: begin
					kind_d = K_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			flush_q <= 1'b0;
			done_q  <= 1'b0;
			comp_q  <= COMP_X;
			sub_q   <= STEP_P1;
			kind_q  <= K_NONE;
		end else begin
			kind_q  <= kind_d;
			done_q  <= flush_q;
			flush_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				comp_q <= COMP_X;
				sub_q  <= STEP_P1;
			end else if (busy_q) begin
				if (sub_q == STEP_HH) begin
					sub_q <= STEP_P1;
					if (comp_q == COMP_Z) begin
						busy_q  <= 1'b0;
						flush_q <= 1'b1;
					end else begin
						comp_q <= comp_q + 2'd1;
					end
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a * mul_b);
		if (start) begin
			e1x_q <= sx(tri_in.bx) - sx(tri_in.ax);
			e1y_q <= sx(tri_in.by_coord) - sx(tri_in.ay);
			e1z_q <= sx(tri_in.bz) - sx(tri_in.az);
			e2x_q <= sx(tri_in.vx) - sx(tri_in.ax);
			e2y_q <= sx(tri_in.vy) - sx(tri_in.ay);
			e2z_q <= sx(tri_in.vz) - sx(tri_in.az);
			rad_q <= '0;
		end else begin
			case (kind_q)
				K_FIRST: acc_q <= prod_q;
				K_SUB:   mag_q <= diff[PW-1] ? diff_neg[MW-1:0] : diff[MW-1:0];
				K_LL:    rad_q <= rad_q + prod_ext;
				K_HL:    rad_q <= rad_q + (prod_ext << (LW + 1));
				K_HH:    rad_q <= rad_q + (prod_ext << (2*LW));
				default: ;
			endcase
		end
	end

	assign done     = done_q;
	assign radicand = rad_q;

endmodule

/* hdl/taa_isqrt.sv */
// Digit-serial floor square root: one radix-4 digit of the radicand per cycle,
// one root bit per cycle. Depends on taa_pkg for defaults.
module taa_isqrt import taa_pkg::*; #(
	parameter  int COORD_BITS = DEF_COORD_BITS,
	localparam int RW         = 4*COORD_BITS + 4,
	localparam int QW         = RW / 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] radicand,
	output logic          done,
	output logic [QW-1:0] root
);

	localparam int CW = $clog2(QW);

	logic [RW-1:0] rad_q;
	logic [QW:0]   rem_q;
	logic [QW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [QW+2:0] rem_n, trial, rem_sub;
	logic          take;

	assign rem_n   = {rem_q, rad_q[RW-1:RW-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_sub = rem_n - trial;
	assign take    = (rem_n >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RW-3:0], 2'b00};
			rem_q  <= take ? rem_sub[QW:0] : rem_n[QW:0];
			root_q <= {root_q[QW-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hdl/triangle_area_accumulator.sv */
// Top level: item sequencer, saturating mesh total and result register.
// Depends on taa_pkg, taa_if, taa_norm and taa_isqrt.
//
//   channel   dir  payload                                          accepted when
//   in_tri    in   ax..vz, last_triangle (taa_in_t)                 valid & ready
//   out_area  out  double_area, mesh_total, saturated, done         valid & ready
//
// One triangle at a time. After the item is taken, the result follows 18 steps of the
// shared multiplier plus flush, then 2*COORD_BITS+2 root steps, then the accumulate
// step.
// in_tri.ready is high only while no triangle is in flight; a held result does
// not block the next item, only its final accumulate waits for out_area.ready.
// Reset clears the sequencer, the running total and the saturation flag.
module triangle_area_accumulator import taa_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int TOTAL_BITS = DEF_TOTAL_BITS
) (
	input logic         clk,
	input logic         arst_n,
	taa_in_if.sink      in_tri,
	taa_out_if.source   out_area
);

	localparam int RW = 4*COORD_BITS + 4;
	localparam int QW = RW / 2;

	taa_state_t              state_q, state_d;
	logic                    in_fire, norm_done, root_done, out_load;
	logic [RW-1:0]           radicand;
	logic [QW-1:0]           root;
	logic                    last_q;
	logic [TOTAL_BITS-1:0]   total_q, new_total;
	logic                    flag_q, new_flag;
	logic [TOTAL_BITS:0]     sum;
	logic [TOTAL_BITS+MESH_W-1:0] total_wide;
	logic [QW+AREA_W-1:0]    area_wide;
	logic                    out_valid_q;
	taa_out_t                out_q;

	assign in_fire = in_tri.valid && in_tri.ready;

	taa_norm #(.COORD_BITS(COORD_BITS)) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.tri_in   (in_tri.data),
		.done     (norm_done),
		.radicand (radicand)
	);

	taa_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (norm_done),
		.radicand (radicand),
		.done     (root_done),
		.root     (root)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire)   state_d = ST_NORM;
			ST_NORM: if (norm_done) state_d = ST_ROOT;
			ST_ROOT: if (root_done) state_d = ST_ACC;
			ST_ACC:  if (out_load)  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_tri.ready = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: in_tri.ready = 1'b1;
			ST_ACC:  out_load     = !out_valid_q || out_area.ready;
			default: ;
		endcase
	end

	// saturating add of this area into the mesh total
	assign sum        = {1'b0, total_q} + (TOTAL_BITS + 1)'(root);
	assign new_total  = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
	assign new_flag   = flag_q | sum[TOTAL_BITS];
	assign total_wide = {{MESH_W{1'b0}}, new_total};
	assign area_wide  = {{AREA_W{1'b0}}, root};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			flag_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
				total_q     <= last_q ? '0 : new_total;
				flag_q      <= last_q ? 1'b0 : new_flag;
			end else if (out_area.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q <= in_tri.data.last_triangle;
		end
		if (out_load) begin
			out_q.double_area     <= area_wide[AREA_W-1:0];
			out_q.mesh_total      <= total_wide[MESH_W-1:0];
			out_q.total_saturated <= new_flag;
			out_q.mesh_done       <= last_q;
		end
	end

	assign out_area.valid = out_valid_q;
	assign out_area.data  = out_q;

endmodule

/* dv/tb.sv */
// Self-checking testbench for triangle_area_accumulator: random and directed triangles,
// predicted twice-areas and saturating mesh totals checked against every result item.
// Depends on taa_pkg, taa_if and the RTL top level.
`timescale 1ns / 1ps

module tb;
	import taa_pkg::*;

	localparam logic [COORD_W-1:0] CMIN = 16'h8000;
	localparam logic [COORD_W-1:0] CMAX = 16'h7fff;
	localparam int LIMIT          = 8_000_000;  // cycles
	localparam int TAIL           = 100;        // cycles after the last result
	localparam int CLIP_MESH_LEN  = 200;        // long mesh of widest triangles
	localparam int LONG_HOLD      = 400;        // long receiver hold-off, cycles

	typedef struct {
		taa_in_t shape;
		bit      rush;  // no idling on either side while this item is in use
	} pending_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	taa_in_if  tri_if ();
	taa_out_if area_if ();

	triangle_area_accumulator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tri   (tri_if),
		.out_area (area_if)
	);

	always #1 clk = ~clk;

	pending_t    tri_q [$];
	taa_out_t    area_q [$];
	logic [63:0] mesh_sum     = '0;
	bit          mesh_clipped = 1'b0;
	int          mismatches   = 0;
	int          results_checked = 0;
	int          cycles       = 0;
	bit          rush_mode    = 1'b0;

	// ---------------------------------------------------------------- prediction

	function automatic longint coord_val(logic [COORD_W-1:0] raw);
		longint v;
		v = longint'(raw & ((1 << DEF_COORD_BITS) - 1));
		if (raw[DEF_COORD_BITS-1])
			v -= longint'(1) << DEF_COORD_BITS;
		return v;
	endfunction

	function automatic void predict_area(taa_in_t t);
		longint             ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
		logic signed [127:0] wx, wy, wz;
		logic [127:0]       norm_sq;
		logic [63:0]        root, cand, total_cap;
		taa_out_t           want;
		ax  = coord_val(t.ax);
		ay  = coord_val(t.ay);
		az  = coord_val(t.az);
		e1x = coord_val(t.bx) - ax;
		e1y = coord_val(t.by_coord) - ay;
		e1z = coord_val(t.bz) - az;
		e2x = coord_val(t.vx) - ax;
		e2y = coord_val(t.vy) - ay;
		e2z = coord_val(t.vz) - az;
		wx = e1y * e2z - e1z * e2y;
		wy = e1z * e2x - e1x * e2z;
		wz = e1x * e2y - e1y * e2x;
		norm_sq = wx * wx + wy * wy + wz * wz;

		root = '0;
		for (int b = 35; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= norm_sq)
				root = cand;
		end

		total_cap = (DEF_TOTAL_BITS >= 64) ? '1 : (64'd1 << DEF_TOTAL_BITS) - 1;
		if (mesh_sum > total_cap - root) begin
			mesh_sum     = total_cap;
			mesh_clipped = 1'b1;
		end else begin
			mesh_sum += root;
		end

		want.double_area     = root[AREA_W-1:0];
		want.mesh_total      = mesh_sum[MESH_W-1:0];
		want.total_saturated = mesh_clipped;
		want.mesh_done       = t.last_triangle;
		area_q.push_back(want);

		if (t.last_triangle) begin
			mesh_sum     = '0;
			mesh_clipped = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_area(taa_out_t got);
		taa_out_t want;
		if (area_q.size() == 0) begin
			$display("%0t: result item with nothing expected, expected none, got area %0d",
				$time, got.double_area);
			mismatches++;
			return;
		end
		want = area_q.pop_front();
		compare_field("double_area", want.double_area, got.double_area);
		compare_field("mesh_total", want.mesh_total, got.mesh_total);
		compare_field("total_saturated", want.total_saturated, got.total_saturated);
		compare_field("mesh_done", want.mesh_done, got.mesh_done);
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic taa_in_t mk_tri(
		logic [COORD_W-1:0] ax, ay, az, bx, by, bz, vx, vy, vz, bit last
	);
		return {ax, ay, az, bx, by, bz, vx, vy, vz, last};
	endfunction

	function automatic void queue_tri(taa_in_t t, bit rush);
		pending_t p;
		p.shape = t;
		p.rush  = rush;
		tri_q.push_back(p);
	endfunction

	function automatic taa_in_t random_triangle(bit last);
		logic [COORD_W-1:0] c [9];
		logic [COORD_W-1:0] base [3];
		logic [COORD_W-1:0] step [3];
		int kind, k;
		kind = $urandom_range(0, 9);
		k    = $urandom_range(0, 5) - 2;
		for (int a = 0; a < 3; a++) begin
			// kept off the rails so a line of points does not wrap
			base[a] = COORD_W'($urandom_range(0, 62000) - 31000);
			step[a] = COORD_W'($urandom_range(0, 1023) - 512);
		end
		for (int i = 0; i < 9; i++) begin
			case (kind)
				0, 1, 2, 3: c[i] = COORD_W'($urandom);
				4, 5: begin
					case ($urandom_range(0, 4))
						0: c[i] = CMIN;
						1: c[i] = CMAX;
						2: c[i] = '0;
						3: c[i] = '1;
						default: c[i] = COORD_W'($urandom);
					endcase
				end
				6: c[i] = COORD_W'($urandom_range(0, 31) - 16);
				7, 8: c[i] = COORD_W'(base[i % 3] + $urandom_range(0, 511) - 256);
				// degenerate: A, A + step, A + k * step are collinear (or coincident)
				default: c[i] = COORD_W'(base[i % 3]
					+ step[i % 3] * ((i < 3) ? 0 : (i < 6) ? 1 : k));
			endcase
		end
		return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], last};
	endfunction

	function automatic void add_meshes(int target);
		int made, len;
		made = 0;
		while (made < target) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			for (int j = 0; j < len; j++)
				queue_tri(random_triangle(j == len - 1), 1'b0);
			made += len;
		end
	endfunction

	// One long mesh of the widest triangle (mirrored and rotated at random) to push the total high.
	function automatic void add_clipping_mesh(int count);
		logic [3*COORD_W-1:0] corner [3];
		logic [3*COORD_W-1:0] flip;
		int rot;
		corner[0] = {CMIN, CMIN, CMIN};
		corner[1] = {CMAX, CMAX, CMIN};
		corner[2] = {CMAX, CMIN, CMAX};
		for (int n = 0; n < count; n++) begin
			flip = '0;
			for (int a = 0; a < 3; a++)
				if ($urandom_range(0, 1))
					flip[COORD_W*a +: COORD_W] = '1;
			rot = $urandom_range(0, 2);
			queue_tri({corner[rot] ^ flip, corner[(rot + 1) % 3] ^ flip,
				corner[(rot + 2) % 3] ^ flip, n == count - 1}, 1'b1);
		end
	endfunction

	function automatic int pick_idle(bit no_gap);
		int r;
		if (no_gap)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(15, 70);
	endfunction

	// ---------------------------------------------------------------- driver

	pending_t next_item;
	int       send_idle = 0;
	int       send_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_if.valid <= 1'b0;
			tri_if.data  <= '0;
			send_idle = 0;
		end else begin
			if (tri_if.valid && tri_if.ready)
				predict_area(tri_if.data);
			if (tri_if.valid && !tri_if.ready) begin
				// hold the offered item
			end else if (send_idle > 0) begin
				tri_if.valid <= 1'b0;
				send_idle--;
			end else if (tri_q.size() > 0) begin
				next_item = tri_q.pop_front();
				rush_mode = next_item.rush;
				tri_if.valid <= 1'b1;
				tri_if.data  <= next_item.shape;
				if (send_calm > 0)
					send_calm--;
				else if ($urandom_range(0, 40) == 0)
					send_calm = $urandom_range(20, 80);
				send_idle = pick_idle(rush_mode || send_calm != 0);
			end else begin
				tri_if.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	int recv_idle = 0;
	int recv_calm = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_if.ready <= 1'b0;
			recv_idle = 0;
			hold_left = 0;
		end else begin
			if (area_if.valid && area_if.ready) begin
				check_area(area_if.data);
				results_checked++;
				// two long hold-offs so the block fills and stalls its input
				if (results_checked == 30 || results_checked == 700)
					hold_left = LONG_HOLD;
				if (recv_calm > 0)
					recv_calm--;
				else if ($urandom_range(0, 40) == 0)
					recv_calm = $urandom_range(20, 80);
				recv_idle = pick_idle(rush_mode || recv_calm != 0);
			end
			if (hold_left > 0) begin
				area_if.ready <= 1'b0;
				hold_left--;
			end else if (recv_idle > 0) begin
				area_if.ready <= 1'b0;
				recv_idle--;
			end else begin
				area_if.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, area_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n <= 1'b0;

		// directed: coincident points at zero and at both rails
		queue_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
		queue_tri(mk_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0), 1'b0);
		queue_tri(mk_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1), 1'b0);
		// widest triangle and its mirror
		queue_tri(mk_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, 1'b0), 1'b0);
		queue_tri(mk_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b0), 1'b0);
		// full-scale right triangles in each plane
		queue_tri(mk_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 1'b0), 1'b0);
		queue_tri(mk_tri(CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, 1'b0), 1'b0);
		queue_tri(mk_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, 1'b1), 1'b0);
		// unit area, and a root that is not exact (sqrt 3)
		queue_tri(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0), 1'b0);
		queue_tri(mk_tri(0, 0, 0, 1, 1, 0, 0, 1, 1, 1'b0), 1'b0);
		// collinear through the origin
		queue_tri(mk_tri(0, 0, 0, 100, 200, 300, 16'hff38, 16'hfe70, 16'hfda8, 1'b0), 1'b0);
		// alternating bit patterns, small negatives
		queue_tri(mk_tri(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
			16'h5555, 16'h5555, 16'haaaa, 1'b0), 1'b0);
		queue_tri(mk_tri(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001,
			16'hffff, 16'hffff, 16'h0001, 1'b0), 1'b0);
		queue_tri(mk_tri(CMAX, CMIN, 0, CMIN, CMAX, 0, 0, 0, CMAX, 1'b1), 1'b0);
		// single-triangle mesh
		queue_tri(mk_tri(0, 0, 0, 3, 0, 0, 0, 4, 0, 1'b1), 1'b0);

		add_meshes(800);
		add_clipping_mesh(CLIP_MESH_LEN);
		add_meshes(800);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (tri_q.size() != 0 || tri_if.valid || area_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
